### rtl/mppk_pkg.sv
package mppk_pkg;

    localparam int GridSize     = 1024;
    localparam int GridBits     = $clog2(GridSize);
    localparam int CordicStages = 18;
    localparam int CordicWidth  = 34;
    localparam int SampleWidth  = 18;
    localparam logic signed [CordicWidth-1:0] CordicX0 = 34'sd652032874;
    localparam logic signed [SampleWidth-1:0] OutMax = 18'sd131071;
    localparam logic signed [SampleWidth-1:0] OutMin = -18'sd131072;

    localparam logic [0:0] RegPotScale  = 1'b0;
    localparam logic [0:0] RegPropScale = 1'b1;

    localparam logic ReqTransmit  = 1'b0;
    localparam logic ReqPropagate = 1'b1;

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    // Data handed from one CORDIC cell to the next
    typedef struct packed {
        logic                          vld;
        logic                          flip;
        logic [31:0]                   z;
        logic signed [CordicWidth-1:0] x;
        logic signed [CordicWidth-1:0] y;
        logic signed [SampleWidth-1:0] sr;
        logic signed [SampleWidth-1:0] si;
    } cell_data_t;

endpackage

### rtl/mppk_cell.sv
// One CORDIC rotation stage; the shift and angle are fixed by the cell index
module mppk_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          idx,
    input  mppk_pkg::cell_data_t d,
    output mppk_pkg::cell_data_t q
);

    mppk_pkg::cell_data_t q_reg;
    mppk_pkg::cell_data_t q_next;
    logic signed [mppk_pkg::CordicWidth-1:0] dx;
    logic signed [mppk_pkg::CordicWidth-1:0] dy;
    logic [31:0] ang;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx     = d.y >>> idx;
        dy     = d.x >>> idx;
        ang    = mppk_pkg::atan_turns(idx);
        q_next = d;
        if (d.z[31])
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + ang;
        end
        else
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - ang;
        end
    end

    // Advance the item; only the valid flag is cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.vld <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### rtl/multislice_phase_propagate_kernel.sv
// Rotates one complex sample per clock by exp(i*phase): transmit mode uses
// potential * potential_phase_scale, propagate mode uses the Fresnel phase of
// the wrapped row/column frequency. A new item may start every cycle; its
// result appears on out_re/out_im with done high for one cycle, after
// 3 phase stages, 18 CORDIC cells and 4 product/round stages.
// The result cannot be stalled: capture it when done is high.
module multislice_phase_propagate_kernel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic signed [17:0] sample_re,
    input  logic signed [17:0] sample_im,
    input  logic [9:0]  row_index,
    input  logic [9:0]  col_index,
    input  logic [15:0] potential,
    output logic        done,
    output logic signed [17:0] out_re,
    output logic signed [17:0] out_im
);

    localparam int CW = mppk_pkg::CordicWidth;
    localparam int SW = mppk_pkg::SampleWidth;
    localparam int GB = mppk_pkg::GridBits;

    logic [23:0] pot_scale_reg;
    logic [31:0] prop_scale_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pot_scale_reg  <= '0;
            prop_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mppk_pkg::RegPotScale:  pot_scale_reg  <= cfg_data[23:0];
                mppk_pkg::RegPropScale: prop_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: squares of the wrapped frequencies, transmit phase product
    logic              v1_reg;
    logic              t1_reg;
    logic [31:0]       ph1_reg;
    logic [2*GB-1:0]   fy2_reg;
    logic [2*GB-1:0]   fx2_reg;
    logic signed [SW-1:0] sr1_reg;
    logic signed [SW-1:0] si1_reg;
    logic signed [GB-1:0] fy;
    logic signed [GB-1:0] fx;
    logic [39:0]       pp;

    always_comb
    begin
        fy = row_index[GB-1:0];
        fx = col_index[GB-1:0];
        pp = {24'd0, potential} * {16'd0, pot_scale_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= req_type;
        ph1_reg <= pp[31:0];
        fy2_reg <= (2*GB)'(fy * fy);
        fx2_reg <= (2*GB)'(fx * fx);
        sr1_reg <= sample_re;
        si1_reg <= sample_im;
    end

    // Stage 2: scaled Fresnel product
    logic              v2_reg;
    logic              t2_reg;
    logic [31:0]       ph2_reg;
    logic [52:0]       pq2_reg;
    logic signed [SW-1:0] sr2_reg;
    logic signed [SW-1:0] si2_reg;
    logic [2*GB:0]     sq;

    assign sq = {1'b0, fy2_reg} + {1'b0, fx2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t2_reg  <= t1_reg;
        ph2_reg <= ph1_reg;
        pq2_reg <= 53'({{(52-2*GB){1'b0}}, sq} * {21'd0, prop_scale_reg});
        sr2_reg <= sr1_reg;
        si2_reg <= si1_reg;
    end

    // Stage 3: round the propagate phase, fold into the right half plane
    mppk_pkg::cell_data_t c0_reg;
    logic [52:0] pr;
    logic [31:0] ph3;

    always_comb
    begin
        pr  = pq2_reg + 53'd128;
        ph3 = (t2_reg == mppk_pkg::ReqPropagate) ? (32'd0 - pr[39:8]) : ph2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg.vld <= 1'b0;
        end
        else
        begin
            c0_reg.vld  <= v2_reg;
            c0_reg.flip <= ph3[31] ^ ph3[30];
            c0_reg.z    <= (ph3[31] ^ ph3[30]) ? ph3 + 32'h80000000 : ph3;
            c0_reg.x    <= mppk_pkg::CordicX0;
            c0_reg.y    <= '0;
            c0_reg.sr   <= sr2_reg;
            c0_reg.si   <= si2_reg;
        end
    end

    // CORDIC chain
    mppk_pkg::cell_data_t chain [0:mppk_pkg::CordicStages];
    assign chain[0] = c0_reg;

    for (genvar g = 0; g < mppk_pkg::CordicStages; g++)
    begin : g_cell
        mppk_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .idx  (5'(g)),
            .d    (chain[g]),
            .q    (chain[g+1])
        );
    end

    // Unfold quadrant, then four partial products
    mppk_pkg::cell_data_t ce;
    logic                 v4_reg;
    logic signed [CW-1:0] c4_reg;
    logic signed [CW-1:0] s4_reg;
    logic signed [SW-1:0] sr4_reg;
    logic signed [SW-1:0] si4_reg;

    assign ce = chain[mppk_pkg::CordicStages];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= ce.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        c4_reg  <= ce.flip ? -ce.x : ce.x;
        s4_reg  <= ce.flip ? -ce.y : ce.y;
        sr4_reg <= ce.sr;
        si4_reg <= ce.si;
    end

    localparam int PW = CW + SW;
    logic                 v5_reg;
    logic signed [PW-1:0] rc_reg;
    logic signed [PW-1:0] is_reg;
    logic signed [PW-1:0] rs_reg;
    logic signed [PW-1:0] ic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg <= PW'(sr4_reg) * PW'(c4_reg);
        is_reg <= PW'(si4_reg) * PW'(s4_reg);
        rs_reg <= PW'(sr4_reg) * PW'(s4_reg);
        ic_reg <= PW'(si4_reg) * PW'(c4_reg);
    end

    // Combine and round
    logic                   v6_reg;
    logic signed [PW:0]     re6_reg;
    logic signed [PW:0]     im6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        re6_reg <= (PW+1)'(rc_reg) - (PW+1)'(is_reg) + (PW+1)'(1 << 29);
        im6_reg <= (PW+1)'(rs_reg) + (PW+1)'(ic_reg) + (PW+1)'(1 << 29);
    end

    // Saturate and drive the result
    logic signed [PW-30:0] re_sh;
    logic signed [PW-30:0] im_sh;
    logic signed [SW-1:0]  re_sat;
    logic signed [SW-1:0]  im_sat;
    logic                  done_reg;
    logic signed [SW-1:0]  out_re_reg;
    logic signed [SW-1:0]  out_im_reg;

    always_comb
    begin
        re_sh = re6_reg[PW:30];
        im_sh = im6_reg[PW:30];
        if (re_sh > (PW-29)'(mppk_pkg::OutMax))
            re_sat = mppk_pkg::OutMax;
        else if (re_sh < (PW-29)'(mppk_pkg::OutMin))
            re_sat = mppk_pkg::OutMin;
        else
            re_sat = re_sh[SW-1:0];
        if (im_sh > (PW-29)'(mppk_pkg::OutMax))
            im_sat = mppk_pkg::OutMax;
        else if (im_sh < (PW-29)'(mppk_pkg::OutMin))
            im_sat = mppk_pkg::OutMin;
        else
            im_sat = im_sh[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_re_reg <= re_sat;
        out_im_reg <= im_sat;
    end

    assign done   = done_reg;
    assign out_re = out_re_reg;
    assign out_im = out_im_reg;

endmodule

### tb/multislice_phase_propagate_kernel_tb.sv
`timescale 1ns / 100ps

module multislice_phase_propagate_kernel_tb;

    typedef struct {
        logic        kind;
        logic [17:0] s_re;
        logic [17:0] s_im;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] pot;
    } sample_item_t;

    typedef struct {
        logic [17:0] re;
        logic [17:0] im;
    } rotated_t;

    localparam int Latency = 25;
    localparam longint CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic        req_type;
    logic signed [17:0] sample_re;
    logic signed [17:0] sample_im;
    logic [9:0]  row_index;
    logic [9:0]  col_index;
    logic [15:0] potential;
    logic        done;
    logic signed [17:0] out_re;
    logic signed [17:0] out_im;

    sample_item_t pending_items[$];
    rotated_t     expected_rot[$];
    logic [23:0]  pot_scale;
    logic [31:0]  prop_scale;
    int           mismatches;
    int           items_sent;
    int           results_seen;
    int           prop_items;
    int           sat_results;
    longint       cycles;
    bit           idle_enable;
    int           drv_gap;

    multislice_phase_propagate_kernel dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .req_type(req_type),
        .sample_re(sample_re), .sample_im(sample_im), .row_index(row_index),
        .col_index(col_index), .potential(potential), .done(done),
        .out_re(out_re), .out_im(out_im)
    );

    always #10 clk = ~clk;

    function automatic longint shr_floor(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint freq_of(logic [9:0] idx);
        longint r;
        r = idx;
        if (r >= mppk_pkg::GridSize / 2)
            r = r - mppk_pkg::GridSize;
        return r;
    endfunction

    function automatic logic [17:0] round_clamp(longint acc);
        longint v;
        v = (acc + (longint'(1) << 29)) >>> 30;
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[17:0];
    endfunction

    // Compute the rotated sample for one item
    function automatic rotated_t rotate_sample(sample_item_t it);
        logic [31:0] tbl[32];
        logic [31:0] phase;
        logic [31:0] z;
        logic [63:0] p;
        logic [63:0] sq;
        longint fy, fx, x, y, dx, dy, sr, si;
        bit flip;
        rotated_t r;
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        sr = longint'(signed'(it.s_re));
        si = longint'(signed'(it.s_im));
        if (it.kind == mppk_pkg::ReqTransmit)
        begin
            p = 64'(it.pot) * 64'(pot_scale);
            phase = p[31:0];
        end
        else
        begin
            fy = freq_of(it.row);
            fx = freq_of(it.col);
            sq = 64'(fy * fy + fx * fx);
            p = sq * 64'(prop_scale);
            p = (p + 64'd128) >> 8;
            phase = 32'd0 - p[31:0];
        end
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        z = flip ? phase + 32'h80000000 : phase;
        x = 652032874;
        y = 0;
        for (int i = 0; i < mppk_pkg::CordicStages; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z[31])
            begin
                x = x + dx;
                y = y - dy;
                z = z + tbl[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - tbl[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        r.re = round_clamp(sr * x - si * y);
        r.im = round_clamp(sr * y + si * x);
        return r;
    endfunction

    // Drive items from the pending queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            drv_gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rot.push_back(rotate_sample(pending_items.pop_front()));
                items_sent <= items_sent + 1;
            end
            if (start && busy)
            begin
                // hold current item
            end
            else if (drv_gap > 0)
            begin
                drv_gap <= drv_gap - 1;
                start <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                drv_gap <= $urandom_range(0, 13);
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                sample_item_t nx;
                nx = pending_items[0];
                start <= 1'b1;
                req_type <= nx.kind;
                sample_re <= nx.s_re;
                sample_im <= nx.s_im;
                row_index <= nx.row;
                col_index <= nx.col;
                potential <= nx.pot;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        rotated_t e;
        int errs;
        errs = 0;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_rot.size() == 0)
            begin
                $display("%0t: unexpected result re=%0d im=%0d", $time, out_re, out_im);
                errs = errs + 1;
            end
            else
            begin
                e = expected_rot.pop_front();
                results_seen <= results_seen + 1;
                if (out_re == 18'h1FFFF || out_re == 18'h20000)
                    sat_results <= sat_results + 1;
                if (out_re !== e.re)
                begin
                    $display("%0t: out_re expected %0d actual %0d", $time,
                             signed'(e.re), out_re);
                    errs = errs + 1;
                end
                if (out_im !== e.im)
                begin
                    $display("%0t: out_im expected %0d actual %0d", $time,
                             signed'(e.im), out_im);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0)
            mismatches <= mismatches + errs;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_item(logic kind, logic [17:0] re, logic [17:0] im,
                            logic [9:0] row, logic [9:0] col, logic [15:0] pot);
        sample_item_t it;
        it.kind = kind;
        it.s_re = re;
        it.s_im = im;
        it.row = row;
        it.col = col;
        it.pot = pot;
        pending_items.push_back(it);
        if (kind == mppk_pkg::ReqPropagate)
            prop_items++;
    endtask

    task automatic add_random(int n);
        logic [17:0] re, im;
        for (int i = 0; i < n; i++)
        begin
            re = 18'($urandom);
            im = 18'($urandom);
            // favor extremes now and then to exercise saturation
            if ($urandom_range(0, 7) == 0)
                re = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            if ($urandom_range(0, 7) == 0)
                im = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            add_item(1'($urandom_range(0, 1)), re, im, 10'($urandom), 10'($urandom),
                     16'($urandom));
        end
    endtask

    // Wait for all results, then let the pipeline drain before a write
    task automatic drain();
        while (pending_items.size() != 0 || start || expected_rot.size() != 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mppk_pkg::RegPotScale)
            pot_scale = val[23:0];
        else
            prop_scale = val;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        req_type = 1'b0;
        sample_re = '0;
        sample_im = '0;
        row_index = '0;
        col_index = '0;
        potential = '0;
        pot_scale = '0;
        prop_scale = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        prop_items = 0;
        sat_results = 0;
        cycles = 0;
        idle_enable = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset scales: zero phase passes the sample through
        add_item(mppk_pkg::ReqTransmit, 18'h1FFFF, 18'h20000, 10'd0, 10'd0, 16'hFFFF);
        add_item(mppk_pkg::ReqPropagate, 18'h20000, 18'h1FFFF, 10'd1023, 10'd512, 16'd0);
        drain();

        // Directed: extremes, both modes, frequency wrap edges
        write_reg(mppk_pkg::RegPotScale, 32'hFFFFFFFF);
        write_reg(mppk_pkg::RegPropScale, 32'hFFFFFFFF);
        add_item(mppk_pkg::ReqTransmit, 18'h1FFFF, 18'h1FFFF, 10'd0, 10'd0, 16'hFFFF);
        add_item(mppk_pkg::ReqTransmit, 18'h20000, 18'h20000, 10'h3FF, 10'h3FF, 16'd0);
        add_item(mppk_pkg::ReqTransmit, 18'h10000, 18'h00000, 10'd5, 10'd7, 16'd1);
        add_item(mppk_pkg::ReqPropagate, 18'h1FFFF, 18'h20000, 10'd0, 10'd0, 16'hFFFF);
        add_item(mppk_pkg::ReqPropagate, 18'h10000, 18'h0, 10'd511, 10'd512, 16'd0);
        add_item(mppk_pkg::ReqPropagate, 18'h10000, 18'h10000, 10'd512, 10'd511, 16'd3);
        add_item(mppk_pkg::ReqPropagate, 18'h20000, 18'h1FFFF, 10'd1023, 10'd1, 16'd0);
        add_item(mppk_pkg::ReqPropagate, 18'h3FFFF, 18'h00001, 10'd512, 10'd512, 16'd9);
        drain();
        write_reg(mppk_pkg::RegPotScale, 32'h00400000);
        write_reg(mppk_pkg::RegPropScale, 32'h80000000);
        for (int q = 0; q < 4; q++)
            add_item(mppk_pkg::ReqTransmit, 18'h1FFFF, 18'h20000, 10'd0, 10'd0,
                     16'(q * 256));
        add_item(mppk_pkg::ReqPropagate, 18'h1FFFF, 18'h1FFFF, 10'd1, 10'd0, 16'd0);
        add_item(mppk_pkg::ReqPropagate, 18'h20000, 18'h20000, 10'd0, 10'd1023, 16'd0);
        drain();

        // Random phases across several scale settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(mppk_pkg::RegPotScale, 32'd0);
                    write_reg(mppk_pkg::RegPropScale, 32'd1);
                end
                1:
                begin
                    write_reg(mppk_pkg::RegPotScale, 32'hFFFFFF);
                    write_reg(mppk_pkg::RegPropScale, '1);
                end
                default:
                begin
                    write_reg(mppk_pkg::RegPotScale, $urandom);
                    write_reg(mppk_pkg::RegPropScale, $urandom);
                end
            endcase
            if (ph == 5)
                idle_enable = 1'b0;
            add_random(300);
            drain();
        end

        $display("Sent %0d items (%0d propagate), checked %0d results, %0d saturated",
                 items_sent, prop_items, results_seen, sat_results);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### filelist.f
rtl/mppk_pkg.sv
rtl/mppk_cell.sv
rtl/multislice_phase_propagate_kernel.sv
tb/multislice_phase_propagate_kernel_tb.sv
